// ===== design/sbh_pkg.sv =====
// sbh_pkg: shared constants and helper functions for the string bucket hash.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package sbh_pkg;

    localparam int unsigned HASH_W       = 32;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned BUCKET_W     = 17;
    localparam int unsigned INDEX_W      = 16;

    localparam int unsigned FOLD_SHIFT   = 3;
    localparam int unsigned MIX_SHIFT_A  = 11;
    localparam int unsigned MIX_SHIFT_B  = 13;
    localparam int unsigned MIX_SHIFT_C  = 23;

    localparam logic [BUCKET_W-1:0] BUCKET_RESET = 17'd1024;
    localparam logic [BUCKET_W-1:0] BUCKET_MAX   = 17'd65536;

    // depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    typedef logic [HASH_W-1:0] t_hash;

    // v ^ (v >> 3)
    function automatic t_hash fold_word(input t_hash v);
        return v ^ (v >> FOLD_SHIFT);
    endfunction

endpackage

`default_nettype wire

// ===== design/sbh_front.sv =====
// sbh_front: byte gathering and word folding, one byte per cycle while i_accept is high.
// Depends on sbh_pkg; pushes the folded hash of each key into the queue.
`default_nettype none

module sbh_front
    import sbh_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [BYTE_W-1:0] i_key_byte,
    input  wire logic              i_last_byte,
    output logic                   o_push,
    output t_hash                  o_hash
);

    t_hash      r_acc,   n_acc;
    t_hash      r_word,  n_word;
    logic [1:0] r_phase, n_phase;
    t_hash      w_word;

    // shift the new byte into the current group
    assign w_word = {r_word[HASH_W-BYTE_W-1:0], i_key_byte};

    // key end: fold the last group or tail into the accumulator
    assign o_push = i_accept && i_last_byte;
    assign o_hash = r_acc + fold_word(w_word);

    always_comb begin
        n_acc   = r_acc;
        n_word  = r_word;
        n_phase = r_phase;
        if (i_accept) begin
            if (i_last_byte) begin
                n_acc   = '0;
                n_word  = '0;
                n_phase = '0;
            end else if (r_phase == 2'd3) begin
                n_acc   = r_acc + fold_word(w_word);
                n_word  = '0;
                n_phase = '0;
            end else begin
                n_word  = w_word;
                n_phase = r_phase + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_word  <= '0;
            r_phase <= '0;
        end else begin
            r_acc   <= n_acc;
            r_word  <= n_word;
            r_phase <= n_phase;
        end
    end

endmodule

`default_nettype wire

// ===== design/sbh_queue.sv =====
// sbh_queue: short register queue of folded hashes between front and back.
// Depends on sbh_pkg for the hash type.
`default_nettype none

module sbh_queue
    import sbh_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_hash i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_hash      o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_hash            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/sbh_back.sv =====
// sbh_back: final mix, bit-serial modulo by the bucket count, result register.
// Depends on sbh_pkg; takes folded hashes from sbh_queue.
`default_nettype none

module sbh_back
    import sbh_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [BUCKET_W-1:0] i_bucket_count,
    input  wire logic                i_q_empty,
    input  wire t_hash               i_q_data,
    output logic                     o_q_pop,
    input  wire logic                i_pop,
    output logic                     o_empty,
    output logic [INDEX_W-1:0]       o_bucket_index,
    output t_hash                    o_mixed_hash
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MIX1 = 3'd1;
    localparam logic [2:0] ST_MIX2 = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    localparam int unsigned CNT_W = $clog2(HASH_W);

    logic [2:0]          r_state;
    t_hash               r_h;
    t_hash               r_sum_a, r_sum_b;
    t_hash               r_mixed;
    t_hash               r_dividend;
    logic [BUCKET_W-1:0] r_divisor;
    logic [BUCKET_W-1:0] r_rem;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_out_valid;
    logic [INDEX_W-1:0]  r_out_index;
    t_hash               r_out_mixed;

    logic [BUCKET_W:0]   w_trial;
    logic [BUCKET_W:0]   w_diff;
    logic                w_ge;
    logic [BUCKET_W-1:0] w_eff;
    logic                w_load_out;

    assign o_q_pop        = (r_state == ST_IDLE) && !i_q_empty;
    assign o_empty        = !r_out_valid;
    assign o_bucket_index = r_out_index;
    assign o_mixed_hash   = r_out_mixed;

    // effective bucket count: zero acts as one, large values saturate
    always_comb begin
        if (i_bucket_count == '0) begin
            w_eff = BUCKET_W'(1);
        end else if (i_bucket_count > BUCKET_MAX) begin
            w_eff = BUCKET_MAX;
        end else begin
            w_eff = i_bucket_count;
        end
    end

    // one restoring step of the modulo
    assign w_trial = {r_rem, r_dividend[HASH_W-1]};
    assign w_diff  = w_trial - {1'b0, r_divisor};
    assign w_ge    = (w_trial >= {1'b0, r_divisor});

    assign w_load_out = (r_state == ST_FIN) && (!r_out_valid || i_pop);

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_h <= i_q_data;
            end
            ST_MIX1: begin
                r_sum_a <= r_h + (r_h >> MIX_SHIFT_A);
                r_sum_b <= (r_h >> MIX_SHIFT_B) + (r_h >> MIX_SHIFT_C);
            end
            ST_MIX2: begin
                r_mixed    <= r_sum_a + r_sum_b;
                r_dividend <= r_sum_a + r_sum_b;
                r_divisor  <= w_eff;
                r_rem      <= '0;
            end
            ST_DIV: begin
                r_rem      <= w_ge ? w_diff[BUCKET_W-1:0] : w_trial[BUCKET_W-1:0];
                r_dividend <= {r_dividend[HASH_W-2:0], 1'b0};
            end
            ST_FIN: begin
            end
            default: begin
            end
        endcase
        if (w_load_out) begin
            r_out_index <= r_rem[INDEX_W-1:0];
            r_out_mixed <= r_mixed;
        end
    end

    // sequencer and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= ST_MIX1;
                    end
                end
                ST_MIX1: begin
                    r_state <= ST_MIX2;
                end
                ST_MIX2: begin
                    r_cnt   <= CNT_W'(HASH_W - 1);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/string_bucket_hash.sv =====
// string_bucket_hash: top level, streaming key hash with bucket selection.
// Depends on sbh_pkg, sbh_front, sbh_queue and sbh_back.
//
// Usage:
//   Input queue side: drive i_key_byte/i_last_byte and raise i_push; a byte
//   transaction completes when i_push is high and o_full is low. The front
//   takes one byte per cycle and stalls only while the hash queue
//   (QUEUE_DEPTH entries) is full.
//   Result queue side: while o_empty is low, o_bucket_index and o_mixed_hash
//   hold the oldest result; raising i_pop takes it.
//   Config: i_cfg_data is written to the bucket count when i_cfg_valid is
//   high; o_cfg_ready is always high.
// Result path: after the last byte of a key the back end pops the queue,
//   mixes in ST_MIX1 and ST_MIX2, runs one modulo step per hash bit, then loads.
// Throughput: one byte per cycle at the input while the queue is not full;
//   the back end takes a new key only once its one-bit-per-cycle modulo loop
//   and result load are through. Shorter keys wait in the queue.
// Reset: clears the accumulator, queue and result; bucket count -> 1024.
// A stalled receiver holds the result; the back end then waits with the
//   next finished result and the queue fills, then o_full rises.
`default_nettype none

module string_bucket_hash
    import sbh_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    output logic                     o_full,
    input  wire logic [BYTE_W-1:0]   i_key_byte,
    input  wire logic                i_last_byte,
    output logic                     o_empty,
    input  wire logic                i_pop,
    output logic [INDEX_W-1:0]       o_bucket_index,
    output logic [HASH_W-1:0]        o_mixed_hash,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [BUCKET_W-1:0] i_cfg_data
);

    logic [BUCKET_W-1:0] r_bucket_count;
    logic                w_accept;
    logic                w_push;
    t_hash               w_push_hash;
    logic                w_q_full, w_q_empty, w_q_pop;
    t_hash               w_q_data;

    assign o_cfg_ready = 1'b1;
    assign o_full      = w_q_full;
    assign w_accept    = i_push && !w_q_full;

    // bucket count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BUCKET_RESET;
        end else if (i_cfg_valid) begin
            r_bucket_count <= i_cfg_data;
        end
    end

    sbh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_key_byte  (i_key_byte),
        .i_last_byte (i_last_byte),
        .o_push      (w_push),
        .o_hash      (w_push_hash)
    );

    sbh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_hash),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_data)
    );

    sbh_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bucket_count (r_bucket_count),
        .i_q_empty      (w_q_empty),
        .i_q_data       (w_q_data),
        .o_q_pop        (w_q_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_bucket_index (o_bucket_index),
        .o_mixed_hash   (o_mixed_hash)
    );

endmodule

`default_nettype wire

// ===== sim/string_bucket_hash_tb.sv =====
// string_bucket_hash_tb: self-checking bench for the streaming key hash with bucket select.
// Depends on sbh_pkg and string_bucket_hash; keys are streamed byte by byte and each
// finished key's bucket index and mixed hash are predicted here and compared in order.
`default_nettype none

module string_bucket_hash_tb;
    import sbh_pkg::*;

    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 600;   // receiver hold-off while the queue fills
    localparam int IDLE_PCT     = 16;

    typedef struct {
        logic [BYTE_W-1:0] key;
        logic              last;
    } t_key_byte;

    typedef struct {
        logic [INDEX_W-1:0] index;
        logic [HASH_W-1:0]  hash;
    } t_bucket_hit;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_push = 1'b0;
    logic                o_full;
    logic [BYTE_W-1:0]   i_key_byte = '0;
    logic                i_last_byte = 1'b0;
    logic                o_empty;
    logic                i_pop = 1'b0;
    logic [INDEX_W-1:0]  o_bucket_index;
    logic [HASH_W-1:0]   o_mixed_hash;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [BUCKET_W-1:0] i_cfg_data = '0;

    // stimulus and scoreboard
    t_key_byte   key_stream[$];
    t_bucket_hit pending_hashes[$];
    int          bytes_queued = 0;
    int          bytes_taken = 0;
    int          error_count = 0;
    logic        byte_fire = 1'b0;
    logic        no_gaps = 1'b0;
    logic        pressure_on = 1'b0;
    int          hold_count = 0;

    // predictor state
    logic [HASH_W-1:0]   key_sum = '0;
    logic [HASH_W-1:0]   byte_group = '0;
    logic [1:0]          group_fill = '0;
    logic [BUCKET_W-1:0] bucket_cfg = BUCKET_RESET;

    string_bucket_hash i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_key_byte     (i_key_byte),
        .i_last_byte    (i_last_byte),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_bucket_index (o_bucket_index),
        .o_mixed_hash   (o_mixed_hash),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Takes one accepted byte into the predicted hash; a marked byte closes the key.
    task automatic absorb_key_byte(input logic [BYTE_W-1:0] kb, input logic lastb);
        logic [HASH_W-1:0]   folded;
        logic [HASH_W-1:0]   mixed;
        logic [BUCKET_W-1:0] n_buckets;
        t_bucket_hit         hit;
        byte_group = {byte_group[HASH_W-BYTE_W-1:0], kb};
        if (!lastb) begin
            if (group_fill == 2'd3) begin
                key_sum    = key_sum + (byte_group ^ (byte_group >> FOLD_SHIFT));
                byte_group = '0;
                group_fill = '0;
            end else begin
                group_fill = group_fill + 2'd1;
            end
        end else begin
            // full last group or 1..3 byte tail: one fold either way
            folded = key_sum + (byte_group ^ (byte_group >> FOLD_SHIFT));
            mixed  = folded + (folded >> MIX_SHIFT_A) + (folded >> MIX_SHIFT_B)
                   + (folded >> MIX_SHIFT_C);
            if (bucket_cfg == '0)
                n_buckets = 17'd1;
            else if (bucket_cfg > BUCKET_MAX)
                n_buckets = BUCKET_MAX;
            else
                n_buckets = bucket_cfg;
            hit.index = INDEX_W'(mixed % n_buckets);
            hit.hash  = mixed;
            pending_hashes.push_back(hit);
            key_sum    = '0;
            byte_group = '0;
            group_fill = '0;
        end
    endtask

    // Monitor: input transactions feed the predictor, result transactions are checked.
    always @(posedge i_clk) begin : monitor
        t_bucket_hit want;
        byte_fire <= i_rst_n && i_push && !o_full;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                bucket_cfg = i_cfg_data;
            if (i_push && !o_full) begin
                absorb_key_byte(i_key_byte, i_last_byte);
                bytes_taken = bytes_taken + 1;
            end
            if (i_pop && !o_empty) begin
                if (pending_hashes.size() == 0) begin
                    $display("%0t: unexpected result index %0d hash %08h",
                             $time, o_bucket_index, o_mixed_hash);
                    error_count = error_count + 1;
                end else begin
                    want = pending_hashes.pop_front();
                    if (o_bucket_index !== want.index) begin
                        $display("%0t: bucket_index expected %0d actual %0d",
                                 $time, want.index, o_bucket_index);
                        error_count = error_count + 1;
                    end
                    if (o_mixed_hash !== want.hash) begin
                        $display("%0t: mixed_hash expected %08h actual %08h",
                                 $time, want.hash, o_mixed_hash);
                        error_count = error_count + 1;
                    end
                end
            end
        end
    end

    // Byte driver: holds a byte until taken, then offers the next or idles.
    always @(negedge i_clk) begin : byte_driver
        t_key_byte item;
        if (!i_push || byte_fire) begin
            if (key_stream.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
                item = key_stream.pop_front();
                i_key_byte  <= item.key;
                i_last_byte <= item.last;
                i_push      <= 1'b1;
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // Result driver: random pops, with one long hold-off while pressure is on.
    always @(negedge i_clk) begin
        if (pressure_on && hold_count < HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
            i_pop      <= 1'b0;
        end else begin
            if (!pressure_on)
                hold_count <= 0;
            i_pop <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic add_byte(input logic [BYTE_W-1:0] kb, input logic lastb);
        t_key_byte item;
        item.key  = kb;
        item.last = lastb;
        key_stream.push_back(item);
        bytes_queued = bytes_queued + 1;
    endtask

    // Random keys: mostly short_max bytes or fewer, now and then up to long_max.
    task automatic queue_random_keys(input int n_bytes, input int short_max, input int long_max);
        int len;
        int sent;
        sent = 0;
        while (sent < n_bytes) begin
            if ($urandom_range(7) == 0)
                len = $urandom_range(long_max, 1);
            else
                len = $urandom_range(short_max, 1);
            for (int k = 0; k < len; k++)
                add_byte(BYTE_W'($urandom_range(255)), k == len - 1);
            sent = sent + len;
        end
    endtask

    // Waits until every byte is taken and every result is back, then lets the back end settle.
    task automatic drain();
        while (bytes_taken != bytes_queued || pending_hashes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_buckets(input logic [BUCKET_W-1:0] value);
        @(negedge i_clk);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Main sequence: reset, directed keys, then random phases under several bucket counts.
    initial begin
        logic [BUCKET_W-1:0] bucket_plan[9];
        bucket_plan = '{17'd0, 17'd65536, 17'd65537, 17'd1, 17'd131071, 17'd3,
                        17'd0, 17'd65535, 17'd1024};
        bucket_plan[6] = BUCKET_W'($urandom_range(65536, 1));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single byte keys at both extremes
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        // length a multiple of four, all ones
        for (int k = 0; k < 4; k++) add_byte(8'hFF, k == 3);
        // three byte tail across the sign boundary
        add_byte(8'h80, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(8'h7F, 1'b1);
        // one zero byte tail after a full zero group
        for (int k = 0; k < 5; k++) add_byte(8'h00, k == 4);
        // two full groups, alternating bits
        for (int k = 0; k < 8; k++) add_byte(k[0] ? 8'h55 : 8'hAA, k == 7);
        add_byte(8'h12, 1'b0);
        add_byte(8'h34, 1'b1);
        drain();

        for (int p = 0; p < 9; p++) begin
            write_buckets(bucket_plan[p]);
            if (p == 7) begin
                // receiver holds off while short keys back the block up
                pressure_on = 1'b1;
                queue_random_keys(150, 3, 3);
                drain();
                pressure_on = 1'b0;
            end else begin
                no_gaps = (p == 8);
                queue_random_keys(115, 12, 40);
                drain();
                no_gaps = 1'b0;
            end
        end

        if (error_count == 0 && pending_hashes.size() == 0) begin
            $display("string_bucket_hash: match");
        end else begin
            $display("string_bucket_hash: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1000000;
        $display("string_bucket_hash: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ===== string_bucket_hash.f =====
design/sbh_pkg.sv
design/sbh_front.sv
design/sbh_queue.sv
design/sbh_back.sv
design/string_bucket_hash.sv
sim/string_bucket_hash_tb.sv
